>>> sv/dss_pkg.sv
// Shared types, constants and helpers for the digraph square substitution unit.
// Depends on nothing; every other file but dss_checker imports this package.
package dss_pkg;

  // Square geometry and letter codes
  localparam int unsigned SQ_DIM   = 5;
  localparam int unsigned LETTER_W = 5;
  localparam int unsigned ROW_W    = SQ_DIM * LETTER_W;
  localparam int unsigned IDX_W    = $clog2(SQ_DIM);
  localparam int unsigned REG_IDX_W = $clog2(SQ_DIM);
  localparam int unsigned CFG_ADDR_W = REG_IDX_W + 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef logic [LETTER_W-1:0]   letter_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef letter_t [SQ_DIM-1:0]  row_t;
  typedef row_t [SQ_DIM-1:0]     square_t;
  typedef logic [REG_IDX_W-1:0]  reg_idx_t;

  localparam letter_t CODE_J = letter_t'(9);
  localparam letter_t CODE_I = letter_t'(8);

  // Register map: square rows occupy indexes 0..SQ_DIM-1
  localparam reg_idx_t REG_ROW0  = reg_idx_t'(0);
  localparam int unsigned REG_COUNT = SQ_DIM;

  // Reset square: a..z without j, row-major
  localparam square_t SQUARE_RESET = {
    25'd27025109, 25'd21613104, 25'd16201099, 25'd10755269, 25'd4294688
  };

  localparam idx_t IDX_LAST = idx_t'(SQ_DIM - 1);

  // Item entering the locate stage
  typedef struct packed {
    logic    valid;
    logic    mode;
    letter_t x;
    letter_t y;
  } pair_t;

  // Coordinates of both letters in the square
  typedef struct packed {
    logic valid;
    logic mode;
    logic ok;
    idx_t r1;
    idx_t c1;
    idx_t r2;
    idx_t c2;
  } loc_t;

  // Cells to read for the substituted pair
  typedef struct packed {
    logic valid;
    logic ok;
    idx_t r1;
    idx_t c1;
    idx_t r2;
    idx_t c2;
  } route_t;

  // Move one place along a row or column, wrapping; back when decrypting
  function automatic idx_t idx_step(input idx_t i, input logic dec);
    idx_t res;
    if (dec) begin
      res = (i == '0) ? IDX_LAST : idx_t'(i - idx_t'(1));
    end else begin
      res = (i == IDX_LAST) ? '0 : idx_t'(i + idx_t'(1));
    end
    return res;
  endfunction

endpackage

>>> sv/dss_locate.sv
// Locate stage: finds row and column of both letters in the key square.
// Depends on dss_pkg.
module dss_locate (
  input  logic             clk,
  input  logic             rst_n,
  input  dss_pkg::square_t square,
  input  dss_pkg::pair_t   pair_in,
  output dss_pkg::loc_t    loc_out
);
  import dss_pkg::*;

  loc_t loc_r, loc_nxt;
  logic hit1, hit2;
  idx_t r1, c1, r2, c2;

  // Compare against every cell; a later match in row-major order wins
  always_comb begin
    hit1 = 1'b0;
    hit2 = 1'b0;
    r1 = '0;
    c1 = '0;
    r2 = '0;
    c2 = '0;
    for (int r = 0; r < SQ_DIM; r++) begin
      for (int c = 0; c < SQ_DIM; c++) begin
        if (square[r][c] == pair_in.x) begin
          hit1 = 1'b1;
          r1 = idx_t'(r);
          c1 = idx_t'(c);
        end
        if (square[r][c] == pair_in.y) begin
          hit2 = 1'b1;
          r2 = idx_t'(r);
          c2 = idx_t'(c);
        end
      end
    end
  end

  always_comb begin
    loc_nxt.valid = pair_in.valid;
    loc_nxt.mode  = pair_in.mode;
    loc_nxt.ok    = hit1 & hit2;
    loc_nxt.r1    = r1;
    loc_nxt.c1    = c1;
    loc_nxt.r2    = r2;
    loc_nxt.c2    = c2;
  end

  // Advance; reset clears the stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loc_r <= '0;
    end else begin
      loc_r <= loc_nxt;
    end
  end

  assign loc_out = loc_r;

endmodule

>>> sv/dss_route.sv
// Route stage: applies the same-row, same-column or rectangle rule.
// Depends on dss_pkg.
module dss_route (
  input  logic           clk,
  input  logic           rst_n,
  input  dss_pkg::loc_t  loc_in,
  output dss_pkg::route_t route_out
);
  import dss_pkg::*;

  route_t route_r, route_nxt;

  // Pick target cells; a doubled letter falls into the same-row case
  always_comb begin
    route_nxt.valid = loc_in.valid;
    route_nxt.ok    = loc_in.ok;
    if (loc_in.r1 == loc_in.r2) begin
      route_nxt.r1 = loc_in.r1;
      route_nxt.c1 = idx_step(loc_in.c1, loc_in.mode);
      route_nxt.r2 = loc_in.r2;
      route_nxt.c2 = idx_step(loc_in.c2, loc_in.mode);
    end else if (loc_in.c1 == loc_in.c2) begin
      route_nxt.r1 = idx_step(loc_in.r1, loc_in.mode);
      route_nxt.c1 = loc_in.c1;
      route_nxt.r2 = idx_step(loc_in.r2, loc_in.mode);
      route_nxt.c2 = loc_in.c2;
    end else begin
      route_nxt.r1 = loc_in.r1;
      route_nxt.c1 = loc_in.c2;
      route_nxt.r2 = loc_in.r2;
      route_nxt.c2 = loc_in.c1;
    end
  end

  // Advance; reset clears the stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      route_r <= '0;
    end else begin
      route_r <= route_nxt;
    end
  end

  assign route_out = route_r;

endmodule

>>> sv/dss_fetch.sv
// Fetch stage: reads the two target cells and drives the result registers.
// Depends on dss_pkg.
module dss_fetch (
  input  logic             clk,
  input  logic             rst_n,
  input  dss_pkg::square_t square,
  input  dss_pkg::route_t  route_in,
  output logic             res_valid,
  output dss_pkg::letter_t res_first,
  output dss_pkg::letter_t res_second,
  output logic             res_ok
);
  import dss_pkg::*;

  logic    valid_r, valid_nxt;
  logic    ok_r, ok_nxt;
  letter_t first_r, first_nxt;
  letter_t second_r, second_nxt;

  // Read cells; zero the pair when a letter was not found
  always_comb begin
    valid_nxt  = route_in.valid;
    ok_nxt     = route_in.ok;
    first_nxt  = route_in.ok ? square[route_in.r1][route_in.c1] : '0;
    second_nxt = route_in.ok ? square[route_in.r2][route_in.c2] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ok_r     <= ok_nxt;
    first_r  <= first_nxt;
    second_r <= second_nxt;
  end

  assign res_valid  = valid_r;
  assign res_ok     = ok_r;
  assign res_first  = first_r;
  assign res_second = second_r;

endmodule

>>> sv/digraph_square_substitution_unit.sv
// Pipeline: an accepted pair passes the pair, locate, route and fetch registers before
// out_valid rises with its result. Throughput: one letter pair per cycle; busy stays low.
// Stages: input/fold, locate (25-cell compare), rule, cell fetch.
// Reset (synchronous, rst_n low) drops all items in flight and restores the
// alphabetic key square in the five row registers.
// Depends on dss_pkg, dss_locate, dss_route and dss_fetch.
module digraph_square_substitution_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // item input
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_mode,
  input  logic [dss_pkg::LETTER_W-1:0]        in_first_letter,
  input  logic [dss_pkg::LETTER_W-1:0]        in_second_letter,
  // results
  output logic                                out_valid,
  output logic [dss_pkg::LETTER_W-1:0]        out_first,
  output logic [dss_pkg::LETTER_W-1:0]        out_second,
  output logic                                out_letters_valid,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dss_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [dss_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [dss_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import dss_pkg::*;

  square_t  square_r, square_nxt;
  pair_t    pair_r, pair_nxt;
  loc_t     loc;
  route_t   route;
  reg_idx_t cfg_idx;
  logic     cfg_wr;

  // Configuration register file
  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_comb begin
    square_nxt = square_r;
    if (cfg_wr && (32'(cfg_idx) < REG_COUNT)) begin
      square_nxt[cfg_idx] = row_t'(pwdata[ROW_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      square_r <= SQUARE_RESET;
    end else begin
      square_r <= square_nxt;
    end
  end

  // Read back a row; unmapped indexes read as zero
  always_comb begin
    prdata = '0;
    if (32'(cfg_idx) < REG_COUNT) begin
      prdata = CFG_DATA_W'(square_r[cfg_idx]);
    end
  end

  // Capture the item and fold j into i
  assign busy = 1'b0;

  always_comb begin
    pair_nxt.valid = start & ~busy;
    pair_nxt.mode  = in_mode;
    pair_nxt.x     = (in_first_letter == CODE_J) ? CODE_I : in_first_letter;
    pair_nxt.y     = (in_second_letter == CODE_J) ? CODE_I : in_second_letter;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_r <= '0;
    end else begin
      pair_r <= pair_nxt;
    end
  end

  dss_locate u_locate (
    .clk     (clk),
    .rst_n   (rst_n),
    .square  (square_r),
    .pair_in (pair_r),
    .loc_out (loc)
  );

  dss_route u_route (
    .clk       (clk),
    .rst_n     (rst_n),
    .loc_in    (loc),
    .route_out (route)
  );

  dss_fetch u_fetch (
    .clk        (clk),
    .rst_n      (rst_n),
    .square     (square_r),
    .route_in   (route),
    .res_valid  (out_valid),
    .res_first  (out_first),
    .res_second (out_second),
    .res_ok     (out_letters_valid)
  );

endmodule

>>> sv/dss_checker.sv
// Port-level checks for the digraph square substitution unit, bound to the top.
// Depends on digraph_square_substitution_unit's port list.
module dss_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [4:0] out_first,
  input logic [4:0] out_second,
  input logic       out_letters_valid
);

  // Every accepted item comes out as a result after passing through the pipeline
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("accepted item did not produce a result after four cycles");

  // No result without a matching accepted item
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##4 !out_valid)
    else $error("result appeared without a matching accepted item");

  // Letters not found give a zero pair
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_letters_valid) |-> (out_first == 5'd0 && out_second == 5'd0))
    else $error("missing letter did not zero the output pair");

  // Reset flushes everything in flight
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe high right after reset");

endmodule

bind digraph_square_substitution_unit dss_checker u_dss_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_first         (out_first),
  .out_second        (out_second),
  .out_letters_valid (out_letters_valid)
);
